// ----- rtl/hbp_pkg.sv -----
// Shared types, constants and helper functions of the hybrid branch predictor.
`default_nettype none

package hbp_pkg;

    // Default table index limits (address bits per table)
    localparam int DEF_MAX_BIMODAL_BITS = 12;
    localparam int DEF_MAX_GSHARE_BITS  = 12;
    localparam int DEF_MAX_CHOOSER_BITS = 12;

    // Configuration register indexes (paddr[4:2])
    localparam logic [2:0] REG_MODE         = 3'd0;
    localparam logic [2:0] REG_BIMODAL_BITS = 3'd1;
    localparam logic [2:0] REG_GSHARE_BITS  = 3'd2;
    localparam logic [2:0] REG_HISTORY_BITS = 3'd3;
    localparam logic [2:0] REG_CHOOSER_BITS = 3'd4;

    // Mode codes; bit 1 set means hybrid
    localparam logic [1:0] MODE_BIMODAL = 2'd0;
    localparam logic [1:0] MODE_GSHARE  = 2'd1;
    localparam logic [1:0] MODE_HYBRID  = 2'd2;

    // Register reset values
    localparam logic [3:0] RST_BIMODAL_BITS = 4'd12;
    localparam logic [3:0] RST_GSHARE_BITS  = 4'd12;
    localparam logic [3:0] RST_HISTORY_BITS = 4'd8;
    localparam logic [3:0] RST_CHOOSER_BITS = 4'd12;

    // Counter reset values
    localparam logic [1:0] CNT_WEAK_TAKEN   = 2'd2;
    localparam logic [1:0] CNT_WEAK_BIMODAL = 2'd1;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] bim_bits;
        logic [3:0] gsh_bits;
        logic [3:0] hist_bits;
        logic [3:0] cho_bits;
    } t_cfg;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EVAL
    } t_back_state;

    // Zero maps to one, above maxv saturates to maxv
    function automatic logic [3:0] clamp_bits(input logic [3:0] v, input logic [4:0] maxv);
        logic [3:0] res;
        if (v == 4'd0) begin
            res = 4'd1;
        end else if ({1'b0, v} > maxv) begin
            res = maxv[3:0];
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [31:0] low_mask(input logic [3:0] n);
        return (32'd1 << n) - 32'd1;
    endfunction

    // 2-bit saturating counter update
    function automatic logic [1:0] train(input logic [1:0] c, input logic t);
        logic [1:0] res;
        if (t) begin
            res = (c == 2'd3) ? c : c + 2'd1;
        end else begin
            res = (c == 2'd0) ? c : c - 2'd1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/hbp_if.sv -----
// Branch item and result item channel interfaces.
`default_nettype none

interface hbp_br_if;
    logic        valid;
    logic        ready;
    logic [31:0] branch_addr;
    logic        taken;

    modport source (output valid, output branch_addr, output taken, input ready);
    modport sink   (input valid, input branch_addr, input taken, output ready);
endinterface

interface hbp_res_if;
    logic        valid;
    logic        ready;
    logic        prediction;
    logic        mispredicted;
    logic        used_gshare;
    logic [31:0] mispredict_total;

    modport source (output valid, output prediction, output mispredicted,
                    output used_gshare, output mispredict_total, input ready);
    modport sink   (input valid, input prediction, input mispredicted,
                    input used_gshare, input mispredict_total, output ready);
endinterface

`default_nettype wire

// ----- rtl/hbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hbp_cfg.sv -----
// APB configuration registers.
`default_nettype none

module hbp_cfg (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    output hbp_pkg::t_cfg     o_cfg
);

    hbp_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= hbp_pkg::MODE_HYBRID;
            r_cfg.bim_bits  <= hbp_pkg::RST_BIMODAL_BITS;
            r_cfg.gsh_bits  <= hbp_pkg::RST_GSHARE_BITS;
            r_cfg.hist_bits <= hbp_pkg::RST_HISTORY_BITS;
            r_cfg.cho_bits  <= hbp_pkg::RST_CHOOSER_BITS;
        end else if (wr_en) begin
            case (reg_idx)
                hbp_pkg::REG_MODE:         r_cfg.mode      <= pwdata[1:0];
                hbp_pkg::REG_BIMODAL_BITS: r_cfg.bim_bits  <= pwdata[3:0];
                hbp_pkg::REG_GSHARE_BITS:  r_cfg.gsh_bits  <= pwdata[3:0];
                hbp_pkg::REG_HISTORY_BITS: r_cfg.hist_bits <= pwdata[3:0];
                hbp_pkg::REG_CHOOSER_BITS: r_cfg.cho_bits  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            hbp_pkg::REG_MODE:         prdata = {30'd0, r_cfg.mode};
            hbp_pkg::REG_BIMODAL_BITS: prdata = {28'd0, r_cfg.bim_bits};
            hbp_pkg::REG_GSHARE_BITS:  prdata = {28'd0, r_cfg.gsh_bits};
            hbp_pkg::REG_HISTORY_BITS: prdata = {28'd0, r_cfg.hist_bits};
            hbp_pkg::REG_CHOOSER_BITS: prdata = {28'd0, r_cfg.cho_bits};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/hbp_front.sv -----
// Front end: accepts branches, forms table indexes, owns the global history.
`default_nettype none

module hbp_front #(
    parameter int MAX_BIMODAL_BITS = hbp_pkg::DEF_MAX_BIMODAL_BITS,
    parameter int MAX_GSHARE_BITS  = hbp_pkg::DEF_MAX_GSHARE_BITS,
    parameter int MAX_CHOOSER_BITS = hbp_pkg::DEF_MAX_CHOOSER_BITS,
    localparam int QW = 3 + MAX_BIMODAL_BITS + MAX_GSHARE_BITS + MAX_CHOOSER_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    hbp_br_if.sink                  i_br,
    input  wire hbp_pkg::t_cfg      i_cfg,
    input  wire hbp_pkg::t_back_stat i_stat,
    input  wire logic               i_q_full,
    output logic                    o_q_push,
    output logic [QW-1:0]           o_q_data
);

    logic [MAX_GSHARE_BITS-1:0]  r_hist;
    logic [MAX_GSHARE_BITS-1:0]  n_hist;
    logic [3:0]                  m2, m1, n, k, s;
    logic [31:0]                 lm_m2, lm_m1, lm_n, lm_k;
    logic [29:0]                 pc;
    logic [MAX_BIMODAL_BITS-1:0] bi;
    logic [MAX_GSHARE_BITS-1:0]  gi, hist_n;
    logic [MAX_CHOOSER_BITS-1:0] ci;
    logic                        accept;

    assign i_br.ready = !i_stat.clearing && !i_q_full;
    assign accept     = i_br.valid && i_br.ready;

    assign m2 = hbp_pkg::clamp_bits(i_cfg.bim_bits, 5'(MAX_BIMODAL_BITS));
    assign m1 = hbp_pkg::clamp_bits(i_cfg.gsh_bits, 5'(MAX_GSHARE_BITS));
    assign n  = hbp_pkg::clamp_bits(i_cfg.hist_bits, {1'b0, m1});
    assign k  = hbp_pkg::clamp_bits(i_cfg.cho_bits, 5'(MAX_CHOOSER_BITS));
    assign s  = m1 - n;

    assign lm_m2 = hbp_pkg::low_mask(m2);
    assign lm_m1 = hbp_pkg::low_mask(m1);
    assign lm_n  = hbp_pkg::low_mask(n);
    assign lm_k  = hbp_pkg::low_mask(k);

    assign pc     = i_br.branch_addr[31:2];
    assign bi     = pc[MAX_BIMODAL_BITS-1:0] & lm_m2[MAX_BIMODAL_BITS-1:0];
    assign ci     = pc[MAX_CHOOSER_BITS-1:0] & lm_k[MAX_CHOOSER_BITS-1:0];
    assign hist_n = r_hist & lm_n[MAX_GSHARE_BITS-1:0];
    // history folds onto the top n bits of the gshare index
    assign gi     = (pc[MAX_GSHARE_BITS-1:0] & lm_m1[MAX_GSHARE_BITS-1:0]) ^ (hist_n << s);

    assign n_hist = (hist_n >> 1) | (MAX_GSHARE_BITS'(i_br.taken) << (n - 4'd1));

    assign o_q_push = accept;
    assign o_q_data = {i_cfg.mode, i_br.taken, bi, gi, ci};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (accept && (i_cfg.mode != hbp_pkg::MODE_BIMODAL)) begin
            r_hist <= n_hist;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hbp_fifo.sv -----
// Two-entry queue between front and back.
`default_nettype none

module hbp_fifo #(
    parameter int W = 40
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic      [W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);

    logic [W-1:0] r_data [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_data[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hbp_back.sv -----
// Back end: counter tables, prediction, training and the result register.
`default_nettype none

module hbp_back #(
    parameter int MAX_BIMODAL_BITS = hbp_pkg::DEF_MAX_BIMODAL_BITS,
    parameter int MAX_GSHARE_BITS  = hbp_pkg::DEF_MAX_GSHARE_BITS,
    parameter int MAX_CHOOSER_BITS = hbp_pkg::DEF_MAX_CHOOSER_BITS,
    localparam int QW = 3 + MAX_BIMODAL_BITS + MAX_GSHARE_BITS + MAX_CHOOSER_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [QW-1:0]       i_q_data,
    input  wire logic                i_q_empty,
    output logic                     o_q_pop,
    output hbp_pkg::t_back_stat      o_stat,
    hbp_res_if.source                o_res
);

    localparam int BW = MAX_BIMODAL_BITS;
    localparam int GW = MAX_GSHARE_BITS;
    localparam int KW = MAX_CHOOSER_BITS;
    localparam int CW = (BW > GW) ? ((BW > KW) ? BW : KW) : ((GW > KW) ? GW : KW);

    hbp_pkg::t_back_state r_state, n_state;

    logic [CW-1:0] r_clr_idx;
    logic [1:0]    r_mode;
    logic          r_taken;
    logic [BW-1:0] r_bi;
    logic [GW-1:0] r_gi;
    logic [KW-1:0] r_ci;

    logic          r_out_valid;
    logic          r_pred;
    logic          r_miss;
    logic          r_use_g;
    logic [31:0]   r_cnt;

    logic [1:0]    q_mode;
    logic          q_taken;
    logic [BW-1:0] q_bi;
    logic [GW-1:0] q_gi;
    logic [KW-1:0] q_ci;

    logic [1:0]    b_rd, g_rd, c_rd;
    logic          b_we, g_we, c_we;
    logic [BW-1:0] b_wa;
    logic [GW-1:0] g_wa;
    logic [KW-1:0] c_wa;
    logic [1:0]    b_wd, g_wd, c_wd;

    logic          clearing, fire, bp, gp, use_g, pred, miss;

    assign {q_mode, q_taken, q_bi, q_gi, q_ci} = i_q_data;

    assign clearing        = (r_state == hbp_pkg::BK_CLEAR);
    assign o_stat.clearing = clearing;
    assign o_q_pop         = (r_state == hbp_pkg::BK_IDLE) && !i_q_empty;
    assign fire            = (r_state == hbp_pkg::BK_EVAL) && (!r_out_valid || o_res.ready);

    // prediction from the registered table reads
    assign bp = b_rd[1];
    assign gp = g_rd[1];
    always_comb begin
        case (r_mode)
            hbp_pkg::MODE_BIMODAL: use_g = 1'b0;
            hbp_pkg::MODE_GSHARE:  use_g = 1'b1;
            default:               use_g = c_rd[1];
        endcase
    end
    assign pred = use_g ? gp : bp;
    assign miss = pred != r_taken;

    // table writes: clearing sweep, else training of the evaluated item
    always_comb begin
        if (clearing) begin
            b_we = (r_clr_idx >> BW) == CW'(0);
            g_we = (r_clr_idx >> GW) == CW'(0);
            c_we = (r_clr_idx >> KW) == CW'(0);
            b_wa = r_clr_idx[BW-1:0];
            g_wa = r_clr_idx[GW-1:0];
            c_wa = r_clr_idx[KW-1:0];
            b_wd = hbp_pkg::CNT_WEAK_TAKEN;
            g_wd = hbp_pkg::CNT_WEAK_TAKEN;
            c_wd = hbp_pkg::CNT_WEAK_BIMODAL;
        end else begin
            b_we = fire && !use_g;
            g_we = fire && use_g;
            // chooser moves only when exactly one predictor was right
            c_we = fire && r_mode[1] && (gp != bp);
            b_wa = r_bi;
            g_wa = r_gi;
            c_wa = r_ci;
            b_wd = hbp_pkg::train(b_rd, r_taken);
            g_wd = hbp_pkg::train(g_rd, r_taken);
            c_wd = hbp_pkg::train(c_rd, gp == r_taken);
        end
    end

    hbp_ram #(.WIDTH(2), .DEPTH(2 ** BW)) u_bim_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_wa),
        .i_wdata (b_wd),
        .i_re    (o_q_pop),
        .i_raddr (q_bi),
        .o_rdata (b_rd)
    );

    hbp_ram #(.WIDTH(2), .DEPTH(2 ** GW)) u_gsh_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_wa),
        .i_wdata (g_wd),
        .i_re    (o_q_pop),
        .i_raddr (q_gi),
        .o_rdata (g_rd)
    );

    hbp_ram #(.WIDTH(2), .DEPTH(2 ** KW)) u_cho_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_wa),
        .i_wdata (c_wd),
        .i_re    (o_q_pop),
        .i_raddr (q_ci),
        .o_rdata (c_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hbp_pkg::BK_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            hbp_pkg::BK_CLEAR: begin
                if (r_clr_idx == {CW{1'b1}}) begin
                    n_state = hbp_pkg::BK_IDLE;
                end
            end
            hbp_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = hbp_pkg::BK_EVAL;
                end
            end
            hbp_pkg::BK_EVAL: begin
                if (fire) begin
                    n_state = hbp_pkg::BK_IDLE;
                end
            end
            default: n_state = hbp_pkg::BK_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= 32'd0;
        end else begin
            if (clearing) begin
                r_clr_idx <= r_clr_idx + CW'(1);
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                if (miss && (r_cnt != 32'hFFFF_FFFF)) begin
                    r_cnt <= r_cnt + 32'd1;
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_mode  <= q_mode;
            r_taken <= q_taken;
            r_bi    <= q_bi;
            r_gi    <= q_gi;
            r_ci    <= q_ci;
        end
        if (fire) begin
            r_pred  <= pred;
            r_miss  <= miss;
            r_use_g <= use_g;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.prediction       = r_pred;
    assign o_res.mispredicted     = r_miss;
    assign o_res.used_gshare      = r_use_g;
    assign o_res.mispredict_total = r_cnt;

endmodule

`default_nettype wire

// ----- rtl/hybrid_branch_predictor.sv -----
// Top level of the tournament (bimodal + gshare + chooser) branch predictor.
//
//  channel  | dir | handshake          | content
//  ---------+-----+--------------------+----------------------------------------------
//  i_br     | in  | valid/ready        | branch_addr[31:0], taken
//  o_res    | out | valid/ready        | prediction, mispredicted, used_gshare,
//           |     |                    | mispredict_total[31:0]
//  apb      | in  | psel/penable/pready| mode, bimodal/gshare/history/chooser index bits
//
// Cycles: the front forms indexes and shifts the history (not in bimodal mode) in the
// accept cycle; the back takes one item at a time: table read in IDLE, then evaluate
// and write back in EVAL, for the read-modify-write of the counter RAMs. Result valid
// rises once the item has passed the queue, the table read and the result register.
// Reset: a clearing pass over all 2**max(MAX_*_BITS) indexes (4096 at defaults) fills
// the tables; i_br.ready stays low during it, APB writes are taken as ever.
// Stalls: a two-entry queue separates front from back. While a result waits for
// o_res.ready the back may read the next item's counters, but it evaluates that
// item only once the result register is free.
`default_nettype none

module hybrid_branch_predictor #(
    parameter int MAX_BIMODAL_BITS = hbp_pkg::DEF_MAX_BIMODAL_BITS,
    parameter int MAX_GSHARE_BITS  = hbp_pkg::DEF_MAX_GSHARE_BITS,
    parameter int MAX_CHOOSER_BITS = hbp_pkg::DEF_MAX_CHOOSER_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    hbp_br_if.sink           i_br,
    hbp_res_if.source        o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    // queue entry: mode, taken and the three table indexes
    localparam int QW = 3 + MAX_BIMODAL_BITS + MAX_GSHARE_BITS + MAX_CHOOSER_BITS;

    hbp_pkg::t_cfg       cfg;
    hbp_pkg::t_back_stat stat;
    logic                q_push, q_pop, q_full, q_empty;
    logic [QW-1:0]       q_wdata, q_rdata;

    hbp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // front: indexing and global history
    hbp_front #(
        .MAX_BIMODAL_BITS (MAX_BIMODAL_BITS),
        .MAX_GSHARE_BITS  (MAX_GSHARE_BITS),
        .MAX_CHOOSER_BITS (MAX_CHOOSER_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_br     (i_br),
        .i_cfg    (cfg),
        .i_stat   (stat),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    hbp_fifo #(.W(QW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: tables, chooser, mispredict counter
    hbp_back #(
        .MAX_BIMODAL_BITS (MAX_BIMODAL_BITS),
        .MAX_GSHARE_BITS  (MAX_GSHARE_BITS),
        .MAX_CHOOSER_BITS (MAX_CHOOSER_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_data  (q_rdata),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_stat    (stat),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire

// ----- rtl/hbp_checker.sv -----
// Port-level assertions for the hybrid branch predictor, bound to the top level.
`default_nettype none

module hbp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_pred,
    input wire logic        i_miss,
    input wire logic        i_use_g,
    input wire logic [31:0] i_total
);

    // tables are being cleared right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready right after reset");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a miss is counted by the time it is shown
    a_miss_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_miss) |-> (i_total != 32'd0))
        else $error("mispredict shown with zero total");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_pred) && $stable(i_miss) && $stable(i_use_g)
             && $stable(i_total)))
        else $error("stalled result changed");

endmodule

bind hybrid_branch_predictor hbp_checker u_hbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_br.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_pred      (o_res.prediction),
    .i_miss      (o_res.mispredicted),
    .i_use_g     (o_res.used_gshare),
    .i_total     (o_res.mispredict_total)
);

`default_nettype wire
